>>> rtl/rrc_pkg.sv
// ---------------------------------------------------------------------------
// rrc_pkg
// Types and codes shared by the rectangle region classifier.
// ---------------------------------------------------------------------------
`default_nettype none
package rrc_pkg;
   localparam int CoordWidth = 20;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type query_x;
      coord_type query_y;
   } req_type;

   typedef struct packed {
      logic [3:0] region_code;
      logic [1:0] first_corner;
      logic [1:0] second_corner;
   } rsp_type;

   localparam logic [3:0] RegionCorner0 = 4'd0;
   localparam logic [3:0] RegionCorner1 = 4'd1;
   localparam logic [3:0] RegionCorner2 = 4'd2;
   localparam logic [3:0] RegionCorner3 = 4'd3;
   localparam logic [3:0] RegionInside  = 4'd4;
   localparam logic [3:0] RegionEdge01  = 4'd5;
   localparam logic [3:0] RegionEdge12  = 4'd6;
   localparam logic [3:0] RegionEdge23  = 4'd7;
   localparam logic [3:0] RegionEdge30  = 4'd8;
   localparam logic [3:0] RegionNone    = 4'd9;
endpackage
`default_nettype wire

>>> rtl/rect_region_classifier_core.sv
// ---------------------------------------------------------------------------
// rect_region_classifier_core
// Classifies a query point against a quadrilateral of four configured corners.
// ---------------------------------------------------------------------------
// Takes one item per cycle unless the result side stalls: a four-stage
// pipeline of differences, products, sum and sign, priority decode. A result
// stall holds the full stages at the output end; items behind move up into
// empty stages. req_ready falls only when all four stages hold items and the
// result is not taken. Corners are written over the csr_ port at 4*i.
`default_nettype none
module rect_region_classifier_core #(
   parameter int COORD_FRAC_BITS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  rrc_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rrc_pkg::rsp_type     rsp_data,
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire  [4:0]           csr_paddr,
   input  wire  [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import rrc_pkg::*;

   localparam int FracBits = COORD_FRAC_BITS;

   coord_type corner_ff [8];
   logic [2:0] csr_index;
   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'b00 && FracBits >= 0) ?
      {{(32-CoordWidth){corner_ff[csr_index][CoordWidth-1]}}, corner_ff[csr_index]} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) corner_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         corner_ff[csr_index] <= csr_pwdata[CoordWidth-1:0];
      end
   end

   // stage enables: advance when downstream is free
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   // stage 1: differences (21 bits)
   logic signed [20:0] dx1_ff [4], dy1_ff [4], qa1_ff [4], aq1_ff [4];
   // stage 2: products (42 bits)
   logic signed [41:0] p2_ff [4], r2_ff [4];
   logic [3:0] vert2_ff, neg2_ff, qsgn2_ff, qz2_ff;
   // stage 3: signs
   logic [3:0] pos3_ff, neg3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int e = 0; e < 4; e++) begin
            dx1_ff[e] <= 21'(corner_ff[2*e]) - 21'(corner_ff[(2*e+2)%8]);
            dy1_ff[e] <= 21'(corner_ff[2*e+1]) - 21'(corner_ff[(2*e+3)%8]);
            qa1_ff[e] <= 21'(req_data.query_x) - 21'(corner_ff[2*e]);
            aq1_ff[e] <= 21'(corner_ff[2*e+1]) - 21'(req_data.query_y);
         end
      end
      if (en2) begin
         for (int e = 0; e < 4; e++) begin
            p2_ff[e]    <= dy1_ff[e] * qa1_ff[e];
            r2_ff[e]    <= dx1_ff[e] * aq1_ff[e];
            vert2_ff[e] <= (dx1_ff[e] == '0);
            neg2_ff[e]  <= dx1_ff[e][20];
            qsgn2_ff[e] <= qa1_ff[e][20];
            qz2_ff[e]   <= (qa1_ff[e] == '0);
         end
      end
      if (en3) begin
         for (int e = 0; e < 4; e++) begin
            logic signed [42:0] num;
            logic np, nn;
            num = 43'(p2_ff[e]) + 43'(r2_ff[e]);
            if (vert2_ff[e]) begin
               np = !qsgn2_ff[e] && !qz2_ff[e];
               nn = qsgn2_ff[e];
            end else begin
               np = (num > 0) ^ (neg2_ff[e] && num != 0);
               nn = (num != 0) && !np;
            end
            pos3_ff[e] <= np;
            neg3_ff[e] <= nn;
         end
      end
   end

   // stage 4: priority decode; edges 0..3 are 01,12,23,30
   rsp_type dec;
   always_comb begin
      logic n01, n12, n30, p23, p30;
      n01 = neg3_ff[0]; n12 = neg3_ff[1]; n30 = neg3_ff[3];
      p23 = pos3_ff[2]; p30 = pos3_ff[3];
      dec = '{RegionNone, 2'd0, 2'd0};
      priority if (!n01 && !n12 && !p30 && !p23) dec = '{RegionInside, 2'd0, 2'd0};
      else if (n01 && p30)          dec = '{RegionCorner0, 2'd1, 2'd3};
      else if (n01 && n12)          dec = '{RegionCorner1, 2'd2, 2'd0};
      else if (n12 && p23)          dec = '{RegionCorner2, 2'd3, 2'd1};
      else if (p23 && p30)          dec = '{RegionCorner3, 2'd0, 2'd2};
      else if (n01 && !n12 && !p30) dec = '{RegionEdge01, 2'd1, 2'd0};
      else if (!n01 && n12 && !p23) dec = '{RegionEdge12, 2'd2, 2'd1};
      else if (!n12 && p23 && !p30) dec = '{RegionEdge23, 2'd3, 2'd2};
      else if (!n01 && !p23 && p30) dec = '{RegionEdge30, 2'd0, 2'd3};
      else                          dec = '{RegionNone, 2'd0, 2'd0};
      if (n30) dec = dec;
   end

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (en4) rsp_ff <= dec;
   end
   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/rrc_checker.sv
// ---------------------------------------------------------------------------
// rrc_checker
// Port-level checks of the region classifier, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module rrc_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input rrc_pkg::rsp_type rsp_data,
   input wire              csr_pready
);
   import rrc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.region_code <= RegionNone)
      else $error("region code out of range");
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.region_code == RegionInside || rsp_data.region_code == RegionNone)
      |-> rsp_data.first_corner == 2'd0 && rsp_data.second_corner == 2'd0)
      else $error("corners set for inside or unmatched");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind rect_region_classifier_core rrc_checker u_rrc_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
   .csr_pready(csr_pready)
);
`default_nettype wire

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle region classifier core.
// ---------------------------------------------------------------------------
// Corners are written over the register port between phases. Query points
// are queued by the stimulus process, offered by a clocked driver and
// classified by an exact sign predictor. A clocked monitor compares each
// result with the oldest predicted region. Both sides idle in random bursts.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import rrc_pkg::*;

   localparam int RegCount = 8;
   localparam logic [4:0] AddrCorner0X = 5'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   coord_type corner_reg [RegCount];
   req_type pending_points [$];
   rsp_type expected_regions [$];
   int mismatch_count = 0;
   int sender_idle = 0;
   int receiver_idle = 0;
   int long_hold = 0;
   bit quiet_phase = 1'b0;
   bit pause_sender = 1'b0;
   int region_seen [10];

   rect_region_classifier_core uut (.*);

   always #2 clock = ~clock;

   function automatic int edge_sign(int a, int b, coord_type qx, coord_type qy);
      longint ax, ay, bx, by, dx, dy, num, px;
      ax = corner_reg[2*a]; ay = corner_reg[2*a+1];
      bx = corner_reg[2*b]; by = corner_reg[2*b+1];
      px = qx;
      dx = ax - bx; dy = ay - by;
      if (dx == 0) return (px > ax) ? 1 : ((px < ax) ? -1 : 0);
      num = dy * (px - ax) + dx * (ay - longint'(qy));
      if (dx < 0) num = -num;
      return (num > 0) ? 1 : ((num < 0) ? -1 : 0);
   endfunction

   function automatic rsp_type classify_point(req_type p);
      int s01, s12, s23, s30;
      rsp_type r;
      s01 = edge_sign(0, 1, p.query_x, p.query_y);
      s12 = edge_sign(1, 2, p.query_x, p.query_y);
      s23 = edge_sign(2, 3, p.query_x, p.query_y);
      s30 = edge_sign(3, 0, p.query_x, p.query_y);
      r = '{RegionNone, 2'd0, 2'd0};
      if (s01 >= 0 && s12 >= 0 && s30 <= 0 && s23 <= 0) r = '{RegionInside, 2'd0, 2'd0};
      else if (s01 < 0 && s30 > 0) r = '{RegionCorner0, 2'd1, 2'd3};
      else if (s01 < 0 && s12 < 0) r = '{RegionCorner1, 2'd2, 2'd0};
      else if (s12 < 0 && s23 > 0) r = '{RegionCorner2, 2'd3, 2'd1};
      else if (s23 > 0 && s30 > 0) r = '{RegionCorner3, 2'd0, 2'd2};
      else if (s01 < 0 && s12 >= 0 && s30 <= 0) r = '{RegionEdge01, 2'd1, 2'd0};
      else if (s01 >= 0 && s12 < 0 && s23 <= 0) r = '{RegionEdge12, 2'd2, 2'd1};
      else if (s12 >= 0 && s23 > 0 && s30 <= 0) r = '{RegionEdge23, 2'd3, 2'd2};
      else if (s01 >= 0 && s23 <= 0 && s30 > 0) r = '{RegionEdge30, 2'd0, 2'd3};
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic write_corner(int idx, coord_type value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= AddrCorner0X + 5'(4 * idx);
      csr_pwdata <= {{12{value[19]}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      corner_reg[idx] = value;
   endtask

   task automatic set_corners(coord_type c [RegCount]);
      for (int i = 0; i < RegCount; i++) write_corner(i, c[i]);
   endtask

   task automatic drain;
      do begin
         while (pending_points.size() != 0 || expected_regions.size() != 0 || req_valid)
            @(posedge clock);
         repeat (8) @(posedge clock);
      end while (pending_points.size() != 0 || expected_regions.size() != 0 || req_valid);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
         1, 2: return coord_type'(20'($urandom));
         default: return coord_type'($signed(11'($urandom)));
      endcase
   endfunction

   task automatic queue_point(coord_type x, coord_type y);
      req_type p;
      p.query_x = x; p.query_y = y;
      pending_points.push_back(p);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_regions.push_back(classify_point(req_data));
         end
         if (!(req_valid && !req_ready)) begin
            if (sender_idle > 0) begin
               sender_idle <= sender_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_points.size() != 0 && !pause_sender) begin
               req_data <= pending_points.pop_front();
               req_valid <= 1'b1;
               if (!quiet_phase && $urandom_range(0, 7) == 0) sender_idle <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_regions.size() == 0) begin
               report_mismatch("unexpected item", rsp_data, 0);
            end else begin
               want = expected_regions.pop_front();
               region_seen[want.region_code]++;
               if (rsp_data.region_code !== want.region_code)
                  report_mismatch("region_code", rsp_data.region_code, want.region_code);
               if (rsp_data.first_corner !== want.first_corner)
                  report_mismatch("first_corner", rsp_data.first_corner, want.first_corner);
               if (rsp_data.second_corner !== want.second_corner)
                  report_mismatch("second_corner", rsp_data.second_corner, want.second_corner);
            end
         end
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= 1'b0;
         end else if (receiver_idle > 0) begin
            receiver_idle <= receiver_idle - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 7) == 0) receiver_idle <= $urandom_range(1, 10);
         end
      end
   end

   initial begin
      #2000000;
      $display("[rect_region_classifier_core] ERROR");
      $finish;
   end

   initial begin
      coord_type square [RegCount];
      coord_type cset [RegCount];
      for (int i = 0; i < RegCount; i++) corner_reg[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all corners at zero: every edge vertical and degenerate
      queue_point(20'sd0, 20'sd0);
      queue_point(20'sd5, -20'sd3);
      queue_point(-20'sd5, 20'sd3);
      drain();

      // axis-aligned square, corners counter-clockwise
      square = '{-20'sd1000, -20'sd1000, 20'sd1000, -20'sd1000,
                 20'sd1000, 20'sd1000, -20'sd1000, 20'sd1000};
      set_corners(square);
      for (int gx = -2; gx <= 2; gx++)
         for (int gy = -2; gy <= 2; gy++)
            queue_point(coord_type'(gx * 1000), coord_type'(gy * 1000));
      drain();

      // extremes of the coordinate range
      cset = '{20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh80000,
               20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF};
      set_corners(cset);
      queue_point(20'sh80000, 20'sh80000);
      queue_point(20'sh7FFFF, 20'sh7FFFF);
      queue_point(20'sh80000, 20'sh7FFFF);
      queue_point(20'sd0, 20'sd0);
      drain();

      // block fills while the receiver holds off
      set_corners(square);
      long_hold = 60;
      for (int i = 0; i < 40; i++) queue_point(rand_coord(), rand_coord());
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         for (int i = 0; i < RegCount; i++) cset[i] = (phase % 3 == 0) ? rand_coord()
            : coord_type'(square[i] + $signed(9'($urandom)));
         set_corners(cset);
         if (phase == 9) quiet_phase = 1'b1;
         for (int i = 0; i < 115; i++) begin
            if (i == 60 && phase == 4) begin
               pause_sender = 1'b1;
               while (expected_regions.size() != 0 || req_valid) @(posedge clock);
               pause_sender = 1'b0;
            end
            if (phase % 3 != 0 && $urandom_range(0, 2) != 0)
               queue_point(coord_type'($urandom_range(0, 4000) - 2000),
                           coord_type'($urandom_range(0, 4000) - 2000));
            else queue_point(rand_coord(), rand_coord());
         end
         drain();
      end

      $display("regions seen: corner %0d/%0d/%0d/%0d inside %0d edge %0d/%0d/%0d/%0d none %0d",
               region_seen[0], region_seen[1], region_seen[2], region_seen[3], region_seen[4],
               region_seen[5], region_seen[6], region_seen[7], region_seen[8], region_seen[9]);
      if (mismatch_count == 0) begin
         $display("[rect_region_classifier_core] OK");
      end else begin
         $display("[rect_region_classifier_core] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
